/* rtl/dq_pkg.sv */
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types and constants of the double-ended queue unit: request codes,
// field widths and the default ring depth.
// ----------------------------------------------------------------------------
package dq_pkg;

	localparam int DATA_W    = 64;
	localparam int CNT_W     = 7;
	localparam int REQ_W     = 3;
	localparam int DEPTH_DEF = 64;
	localparam int S_USER_W  = REQ_W;
	localparam int M_USER_W  = 3 + CNT_W;

	typedef enum logic [REQ_W-1:0] {
		REQ_PUSH_FRONT = 3'd0,
		REQ_PUSH_BACK  = 3'd1,
		REQ_POP_FRONT  = 3'd2,
		REQ_POP_BACK   = 3'd3,
		REQ_PEEK_FRONT = 3'd4,
		REQ_PEEK_BACK  = 3'd5,
		REQ_CLEAR      = 3'd6,
		REQ_PRINT      = 3'd7
	} req_t;

endpackage

/* rtl/dq_ram.sv */
// ----------------------------------------------------------------------------
// dq_ram
// Generic single-clock RAM: one write port, one read port with a registered
// read. Read data holds while the read enable is low.
// ----------------------------------------------------------------------------
module dq_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/double_ended_queue_unit.sv */
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// Bounded double-ended queue of signed 64-bit entries kept in a ring RAM.
// Pushes, pops and peeks at either end, clear, and a front-to-back print.
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  s_*      in   tuser: req_type[2:0]; tdata: push_value[63:0]
//  m_*      out  tdata: data[63:0]; tuser: data_valid, count[6:0], is_empty,
//                overflow; tlast: last
//
//  Push, clear, and pop/peek/print of an empty queue: answered straight from the request, no RAM read.
//  Pop and peek: answered through the registered read of the entry RAM.
//  Print of N entries: one RAM read per entry streamed out.
//  Reset clears head and count; the entry RAM needs no clearing pass.
//  A stalled result waits in the output register; reads then pause.
// ----------------------------------------------------------------------------
module double_ended_queue_unit
	import dq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [DATA_W-1:0]   s_tdata,  // push_value[63:0]
	input  logic [S_USER_W-1:0] s_tuser,  // req_type[2:0]
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [DATA_W-1:0]   m_tdata,  // data[63:0]
	output logic [M_USER_W-1:0] m_tuser,  // data_valid, count[6:0], is_empty, overflow
	output logic                m_tlast
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [IW:0]   DEPTH_W = (IW + 1)'(DEPTH);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
	localparam logic [IW-1:0] LAST_SLOT = IW'(DEPTH - 1);

	logic [IW-1:0] head_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] left_q;
	logic [IW-1:0] off_q;
	logic          pend_q;
	logic          pend_last_q;

	logic                m_tvalid_q;
	logic [DATA_W-1:0]   m_tdata_q;
	logic [M_USER_W-1:0] m_tuser_q;
	logic                m_tlast_q;

	logic          busy, out_free, acc, load, issue;
	req_t          req;
	logic          empty, full;
	logic [IW-1:0] head_nx;
	logic [CW-1:0] cnt_nx;
	logic          we, re, re_acc;
	logic [IW-1:0] waddr, raddr, raddr_acc;
	logic [DATA_W-1:0] rdata;
	logic          dir_load, dir_ovf, dir_none;
	logic [CW-1:0] left_acc;
	logic          pend_last_acc;

	function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] a, input logic [IW-1:0] b);
		logic [IW:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= DEPTH_W) begin
			s = s - DEPTH_W;
		end
		return s[IW-1:0];
	endfunction

	assign busy     = pend_q || (left_q != '0);
	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = !busy && out_free;
	assign acc      = s_tvalid && s_tready;
	assign req      = req_t'(s_tuser);
	assign empty    = (cnt_q == '0);
	assign full     = (cnt_q >= DEPTH_C);

	assign load  = pend_q && out_free;
	assign issue = (left_q != '0) && (!pend_q || load);

	always_comb begin
		head_nx       = head_q;
		cnt_nx        = cnt_q;
		we            = 1'b0;
		waddr         = head_q;
		re_acc        = 1'b0;
		raddr_acc     = head_q;
		dir_load      = 1'b1;
		dir_ovf       = 1'b0;
		dir_none      = 1'b0;
		left_acc      = '0;
		pend_last_acc = 1'b1;
		unique case (req)
			REQ_PUSH_FRONT: begin
				if (full) begin
					dir_ovf = 1'b1;
				end else begin
					head_nx = (head_q == '0) ? LAST_SLOT : head_q - 1'b1;
					we      = 1'b1;
					waddr   = head_nx;
					cnt_nx  = cnt_q + 1'b1;
				end
			end
			REQ_PUSH_BACK: begin
				if (full) begin
					dir_ovf = 1'b1;
				end else begin
					we     = 1'b1;
					waddr  = wrap_add(head_q, cnt_q[IW-1:0]);
					cnt_nx = cnt_q + 1'b1;
				end
			end
			REQ_POP_FRONT, REQ_PEEK_FRONT: begin
				if (empty) begin
					dir_none = 1'b1;
				end else begin
					dir_load  = 1'b0;
					re_acc    = 1'b1;
					raddr_acc = head_q;
					if (req == REQ_POP_FRONT) begin
						head_nx = wrap_add(head_q, IW'(1));
						cnt_nx  = cnt_q - 1'b1;
					end
				end
			end
			REQ_POP_BACK, REQ_PEEK_BACK: begin
				if (empty) begin
					dir_none = 1'b1;
				end else begin
					dir_load  = 1'b0;
					re_acc    = 1'b1;
					raddr_acc = wrap_add(head_q, IW'(cnt_q - 1'b1));
					if (req == REQ_POP_BACK) begin
						cnt_nx = cnt_q - 1'b1;
					end
				end
			end
			REQ_CLEAR: begin
				head_nx = '0;
				cnt_nx  = '0;
			end
			REQ_PRINT: begin
				if (empty) begin
					dir_none = 1'b1;
				end else begin
					dir_load      = 1'b0;
					re_acc        = 1'b1;
					raddr_acc     = head_q;
					left_acc      = cnt_q - 1'b1;
					pend_last_acc = (cnt_q == CW'(1));
				end
			end
		endcase
	end

	assign re    = (acc && re_acc) || issue;
	assign raddr = issue ? wrap_add(head_q, off_q) : raddr_acc;

	dq_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (acc && we),
		.waddr(waddr),
		.wdata(s_tdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			cnt_q       <= '0;
			left_q      <= '0;
			off_q       <= '0;
			pend_q      <= 1'b0;
			pend_last_q <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (acc) begin
				head_q <= head_nx;
				cnt_q  <= cnt_nx;
				if (re_acc) begin
					left_q      <= left_acc;
					off_q       <= IW'(1);
					pend_last_q <= pend_last_acc;
				end
			end
			if (issue) begin
				left_q      <= left_q - 1'b1;
				off_q       <= off_q + 1'b1;
				pend_last_q <= (left_q == CW'(1));
			end
			pend_q <= re || (pend_q && !load);
			if (acc && dir_load) begin
				m_tvalid_q <= 1'b1;
			end else if (load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && dir_load) begin
			m_tdata_q <= dir_none ? '1 : '0;
			m_tuser_q <= {dir_ovf, (cnt_nx == '0), CNT_W'(cnt_nx), 1'b0};
			m_tlast_q <= 1'b1;
		end else if (load) begin
			m_tdata_q <= rdata;
			m_tuser_q <= {1'b0, (cnt_q == '0), CNT_W'(cnt_q), 1'b1};
			m_tlast_q <= pend_last_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= DEPTH_C)
		else $error("entry count exceeds depth");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(acc && we && re))
		else $error("write and read issued in the same cycle");

	a_read_lands: assert property (@(posedge clk) disable iff (!arst_n)
		re |=> pend_q)
		else $error("issued read not held as pending");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q && !load) |-> !re)
		else $error("read issued over unconsumed read data");

	a_idle_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (!pend_q && left_q == '0))
		else $error("request accepted while a read run is active");

endmodule
